@@ rtl/core/midi_event_router_with_cc_learn_unit_macros.svh @@
// ----------------------------------------------------------------------------
// MIDI event router assertion macros
// Shared concurrent assertion forms, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef MIDI_EVENT_ROUTER_WITH_CC_LEARN_UNIT_MACROS_SVH
`define MIDI_EVENT_ROUTER_WITH_CC_LEARN_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// condition implies consequence in the same cycle
`define MERC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("merc assertion failed");

// condition implies consequence in the next cycle
`define MERC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("merc assertion failed");

`else

`define MERC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define MERC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/core/merc_pkg.sv @@
// ----------------------------------------------------------------------------
// MIDI event router package
// Request and result types, action codes and MIDI constants
// ----------------------------------------------------------------------------
`default_nettype none

package merc_pkg;

    // request kinds
    localparam logic CMD_EVENT = 1'b0;
    localparam logic CMD_LEARN = 1'b1;

    // event byte counts that carry a message
    localparam logic [7:0] BC_TWO   = 8'd2;
    localparam logic [7:0] BC_THREE = 8'd3;

    // status bytes
    localparam logic [7:0] ST_NOTE_ON_LO  = 8'h90;
    localparam logic [7:0] ST_NOTE_ON_HI  = 8'h9F;
    localparam logic [7:0] ST_NOTE_OFF_LO = 8'h80;
    localparam logic [7:0] ST_NOTE_OFF_HI = 8'h8F;
    localparam logic [7:0] ST_CC_CH1      = 8'hB0;

    // controller numbers and thresholds
    localparam logic [6:0] CC_SUSTAIN        = 7'h40;
    localparam logic [7:0] SUSTAIN_THRESHOLD = 8'd63;
    localparam logic [6:0] LOWEST_NOTE_RESET = 7'd21;

    typedef enum logic [2:0] {
        ACT_NONE       = 3'd0,
        ACT_NOTE_START = 3'd1,
        ACT_NOTE_STOP  = 3'd2,
        ACT_PARAM_SET  = 3'd3,
        ACT_SUSTAIN    = 3'd4,
        ACT_LEARNED    = 3'd5
    } action_t;

    typedef struct packed {
        logic       cmd;
        logic [7:0] byte_count;
        logic [7:0] msg_byte0;
        logic [7:0] msg_byte1;
        logic [7:0] msg_byte2;
        logic       learn_on;
        logic [6:0] learn_controller;
    } merc_evt_t;

    typedef struct packed {
        action_t    action;
        logic [6:0] note_number;
        logic [7:0] velocity;
        logic [6:0] target_controller;
        logic [7:0] param_value;
        logic       sustain_on;
        logic [6:0] dropped_controller;
        logic [6:0] learned_cc;
    } merc_res_t;

endpackage

`default_nettype wire

@@ rtl/core/midi_event_router_with_cc_learn_unit.sv @@
// ----------------------------------------------------------------------------
// MIDI event router with CC learn
// Decodes MIDI events under running status, routes notes, sustain and bound
// control changes, and learns controller to CC bindings
// ----------------------------------------------------------------------------
// Each request yields exactly one result from the result register, and
// a new request is taken every cycle while the result side keeps up. A request
// is accepted into a decode stage together with a read of both binding tables
// (CC to controller and controller to CC, one synchronous read port each); the
// decode stage resolves the request, writes back at most one entry of each
// table and loads the result register. A write and the next request's read of
// the same entry in the same cycle are forwarded inside the table. Per-entry
// valid bits clear both tables at reset, so no clearing pass is needed.
// lowest_note may be written only while no request is in flight.
`default_nettype none

`include "midi_event_router_with_cc_learn_unit_macros.svh"

module midi_event_router_with_cc_learn_unit #(
    parameter int NUM_CONTROLLERS = 64
) (
    input  wire                 clk,
    input  wire                 rst_n,
    // event and learn requests
    input  wire                 evt_valid,
    output logic                evt_stall,
    input  merc_pkg::merc_evt_t evt,
    // results
    output logic                res_valid,
    input  wire                 res_stall,
    output merc_pkg::merc_res_t res,
    // lowest_note register write
    input  wire                 cfg_valid,
    output logic                cfg_ready,
    input  wire  [6:0]          cfg_data
);

    import merc_pkg::*;

    localparam int         CW  = (NUM_CONTROLLERS > 1) ? $clog2(NUM_CONTROLLERS) : 1;
    localparam logic [6:0] NC7 = 7'(NUM_CONTROLLERS);

    // pipeline control
    logic      evt_acc;
    logic      s1_adv;
    logic      s1_valid_reg;
    logic      s1_valid_next;
    merc_evt_t s1_item_reg;
    logic      res_valid_reg;
    logic      res_valid_next;
    merc_res_t res_reg;
    merc_res_t res_calc;

    // architectural state
    logic [6:0]                 lowest_note_reg;
    logic [7:0]                 rs_reg;
    logic [7:0]                 rs_next;
    logic                       learn_active_reg;
    logic                       learn_active_next;
    logic [6:0]                 learn_target_reg;
    logic [6:0]                 learn_target_next;
    logic [127:0]               own_valid_reg;
    logic [127:0]               own_valid_next;
    logic [NUM_CONTROLLERS-1:0] ctl_valid_reg;
    logic [NUM_CONTROLLERS-1:0] ctl_valid_next;

    // binding tables
    logic [6:0] own_mem [128];
    logic [6:0] ctl_mem [NUM_CONTROLLERS];
    logic [6:0] own_rd_reg;
    logic [6:0] ctl_rd_reg;
    logic [6:0] own_rd_addr;
    logic [CW-1:0] ctl_rd_addr;

    // decode stage signals
    logic          learn_op;
    logic [7:0]    status;
    logic [7:0]    note;
    logic [7:0]    velo;
    logic          note_ok;
    logic [6:0]    s1_cc;
    logic          learning;
    logic [CW-1:0] t_idx;
    logic [6:0]    old_owner;
    logic          old_ok;
    logic [CW-1:0] old_idx;
    logic          oldkey_ok;

    // handshake
    assign s1_adv    = s1_valid_reg && (!res_valid_reg || !res_stall);
    assign evt_stall = s1_valid_reg && !s1_adv;
    assign evt_acc   = evt_valid && !evt_stall;
    assign cfg_ready = 1'b1;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign s1_valid_next  = evt_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
    assign res_valid_next = s1_adv ? 1'b1 : (res_stall ? res_valid_reg : 1'b0);

    // table lookups for the decode stage
    assign s1_cc     = s1_item_reg.msg_byte1[6:0];
    assign learning  = learn_active_reg && (learn_target_reg != 7'd0)
                       && (learn_target_reg <= NC7);
    assign t_idx     = CW'(learn_target_reg - 7'd1);
    assign old_owner = own_valid_reg[s1_cc] ? own_rd_reg : 7'd0;
    assign old_ok    = (old_owner != 7'd0) && (old_owner <= NC7);
    assign old_idx   = CW'(old_owner - 7'd1);
    assign oldkey_ok = learning && ctl_valid_reg[t_idx];

    // read addresses for the request being accepted
    assign own_rd_addr = evt.msg_byte1[6:0];
    assign ctl_rd_addr = CW'(learn_target_next - 7'd1);

    // message fields under running status
    always_comb
    begin
        status = rs_reg;
        note   = s1_item_reg.msg_byte0;
        velo   = s1_item_reg.msg_byte1;
        if (s1_item_reg.byte_count == BC_THREE)
        begin
            status = s1_item_reg.msg_byte0;
            note   = s1_item_reg.msg_byte1;
            velo   = s1_item_reg.msg_byte2;
        end
    end

    assign note_ok = !note[7] && (note[6:0] >= lowest_note_reg);

    // decode, result and next state
    always_comb
    begin
        res_calc          = '0;
        rs_next           = rs_reg;
        learn_active_next = learn_active_reg;
        learn_target_next = learn_target_reg;
        learn_op          = 1'b0;
        if (s1_item_reg.cmd == CMD_LEARN)
        begin
            if (s1_item_reg.learn_on || (s1_item_reg.learn_controller == learn_target_reg))
            begin
                learn_active_next = s1_item_reg.learn_on;
                learn_target_next = s1_item_reg.learn_controller;
            end
        end
        else
        begin
            case (s1_item_reg.byte_count)
                BC_THREE: rs_next = s1_item_reg.msg_byte0;
                BC_TWO:   rs_next = rs_reg;
                default:  rs_next = 8'd0;
            endcase
            if ((s1_item_reg.byte_count == BC_THREE) || (s1_item_reg.byte_count == BC_TWO))
            begin
                if ((status >= ST_NOTE_ON_LO) && (status <= ST_NOTE_ON_HI))
                begin
                    if (note_ok)
                    begin
                        res_calc.note_number = note[6:0];
                        if (velo != 8'd0)
                        begin
                            res_calc.action   = ACT_NOTE_START;
                            res_calc.velocity = velo;
                        end
                        else
                        begin
                            res_calc.action = ACT_NOTE_STOP;
                        end
                    end
                end
                else if ((status >= ST_NOTE_OFF_LO) && (status <= ST_NOTE_OFF_HI))
                begin
                    if (note_ok)
                    begin
                        res_calc.action      = ACT_NOTE_STOP;
                        res_calc.note_number = note[6:0];
                    end
                end
                else if ((s1_item_reg.byte_count == BC_THREE)
                         && (s1_item_reg.msg_byte0 == ST_CC_CH1)
                         && !s1_item_reg.msg_byte1[7])
                begin
                    if (learning)
                    begin
                        learn_op                    = 1'b1;
                        res_calc.action             = ACT_LEARNED;
                        res_calc.target_controller  = learn_target_reg;
                        res_calc.learned_cc         = s1_cc;
                        if (old_ok && (old_owner != learn_target_reg))
                        begin
                            res_calc.dropped_controller = old_owner;
                        end
                        learn_active_next = 1'b0;
                        learn_target_next = 7'd0;
                    end
                    else if (old_ok)
                    begin
                        res_calc.action            = ACT_PARAM_SET;
                        res_calc.target_controller = old_owner;
                        res_calc.param_value       = s1_item_reg.msg_byte2;
                    end
                    else if (s1_cc == CC_SUSTAIN)
                    begin
                        res_calc.action     = ACT_SUSTAIN;
                        res_calc.sustain_on = (s1_item_reg.msg_byte2 > SUSTAIN_THRESHOLD)
                                              && !s1_item_reg.msg_byte2[7];
                    end
                end
            end
        end
        // hold state unless the request leaves the decode stage
        if (!s1_adv)
        begin
            rs_next           = rs_reg;
            learn_active_next = learn_active_reg;
            learn_target_next = learn_target_reg;
            learn_op          = 1'b0;
        end
    end

    // binding valid bits: drop old pairs, then mark the new pair
    always_comb
    begin
        own_valid_next = own_valid_reg;
        ctl_valid_next = ctl_valid_reg;
        if (learn_op)
        begin
            if (oldkey_ok)
            begin
                own_valid_next[ctl_rd_reg] = 1'b0;
            end
            if (old_ok)
            begin
                ctl_valid_next[old_idx] = 1'b0;
            end
            own_valid_next[s1_cc] = (s1_cc != 7'd0);
            ctl_valid_next[t_idx] = (s1_cc != 7'd0);
        end
    end

    // cc to controller table with write forwarding
    always_ff @(posedge clk)
    begin
        if (learn_op)
        begin
            own_mem[s1_cc] <= learn_target_reg;
        end
        if (evt_acc)
        begin
            if (learn_op && (s1_cc == own_rd_addr))
            begin
                own_rd_reg <= learn_target_reg;
            end
            else
            begin
                own_rd_reg <= own_mem[own_rd_addr];
            end
        end
    end

    // controller to cc table with write forwarding
    always_ff @(posedge clk)
    begin
        if (learn_op)
        begin
            ctl_mem[t_idx] <= s1_cc;
        end
        if (evt_acc)
        begin
            if (learn_op && (t_idx == ctl_rd_addr))
            begin
                ctl_rd_reg <= s1_cc;
            end
            else
            begin
                ctl_rd_reg <= ctl_mem[ctl_rd_addr];
            end
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (evt_acc)
        begin
            s1_item_reg <= evt;
        end
        if (s1_adv)
        begin
            res_reg <= res_calc;
        end
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            res_valid_reg    <= 1'b0;
            lowest_note_reg  <= LOWEST_NOTE_RESET;
            rs_reg           <= 8'd0;
            learn_active_reg <= 1'b0;
            learn_target_reg <= 7'd0;
            own_valid_reg    <= '0;
            ctl_valid_reg    <= '0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            res_valid_reg    <= res_valid_next;
            rs_reg           <= rs_next;
            learn_active_reg <= learn_active_next;
            learn_target_reg <= learn_target_next;
            own_valid_reg    <= own_valid_next;
            ctl_valid_reg    <= ctl_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                lowest_note_reg <= cfg_data;
            end
        end
    end

    // a learned binding ends learn mode
    `MERC_ASSERT_NEXT(a_learn_ends, clk, rst_n, learn_op, !learn_active_reg && (learn_target_reg == 7'd0))
    // a nonzero learned cc is bound right after
    `MERC_ASSERT_NEXT(a_bind_set, clk, rst_n, learn_op && (s1_cc != 7'd0), own_valid_reg[$past(s1_cc)])
    // a new result only comes from the decode stage
    `MERC_ASSERT_IMPLIES(a_res_source, clk, rst_n, $rose(res_valid_reg), $past(s1_adv))

endmodule

`default_nettype wire
